>>> src/msr_pkg.sv
// Shared constants, types and helpers for the maximum solar radiation pipeline.
package msr_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int OUT_FRAC_BITS     = 10;
    localparam int ATAN_ENTRIES      = 24;

    // Q16 trig values and products
    localparam int Q_W = 18;
    typedef logic signed [Q_W-1:0] q16_t;

    // Q16 radians, wide enough for an unreduced day angle
    localparam int Z_W = 21;
    typedef logic signed [Z_W-1:0] ang_t;

    localparam int H_W      = 18;
    localparam int SQ_RAD_W = 34;
    localparam int ROOT_W   = SQ_RAD_W / 2;

    localparam int Q_ONE     = 65536;
    localparam int Q_PI      = 205887;
    localparam int Q_HALF_PI = 102944;
    localparam int Q_TWO_PI  = 411775;
    localparam int Q_GAIN    = 39797;

    localparam int DAY_OFFSET = 82;
    localparam int DAY_SCALE  = 6553600;
    localparam int DAY_DIV    = 5809;
    localparam int LAT_SCALE  = 2058874;
    localparam int LAT_DIV    = 180000;
    localparam int LAT_LIMIT  = 9000;
    localparam int SIN_TILT   = 26214;
    localparam int ECC        = 2163;

    localparam logic [15:0] ATAN_Q16 [ATAN_ENTRIES] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
        16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    // Q16 product, rounded half up
    function automatic q16_t qmul(input q16_t a, input q16_t b);
        logic signed [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(32768);
        return Q_W'(p >>> 16);
    endfunction

endpackage

>>> src/msr_argdiv.sv
// Angle argument: (neg ? -1 : 1) * floor((mag*SCALE + BIAS) / DIVISOR), three stages.
module msr_argdiv #(
    parameter int              MAG_W   = 9,
    parameter int              X_W     = 32,
    parameter longint unsigned SCALE   = 1,
    parameter longint unsigned BIAS    = 0,
    parameter longint unsigned DIVISOR = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic               in_neg,
    input  logic [MAG_W-1:0]   in_mag,
    output logic               out_vld,
    output msr_pkg::ang_t      out_z
);

    localparam int P_W = 2 * X_W + 1;
    // ceil(2^X_W / DIVISOR): estimate is exact or one too high
    localparam logic [X_W:0] RECIP = (X_W+1)'(((64'd1 << X_W) + DIVISOR - 64'd1) / DIVISOR);

    logic           vld1_reg, vld2_reg, vld3_reg;
    logic           neg1_reg, neg2_reg;
    logic [X_W-1:0] x1_reg, x2_reg;
    logic [P_W-1:0] p2_reg;
    msr_pkg::ang_t  z3_reg;

    logic [X_W-1:0] x_next;
    logic [P_W-1:0] p_next;
    logic [X_W-1:0] qe;
    logic [P_W-1:0] chk;
    logic [X_W-1:0] q;
    msr_pkg::ang_t  qm, z_next;

    always_comb begin
        x_next = X_W'(in_mag) * X_W'(SCALE) + X_W'(BIAS);
        p_next = P_W'(x1_reg) * P_W'(RECIP);
        qe     = X_W'(p2_reg >> X_W);
        chk    = P_W'(qe) * P_W'(DIVISOR);
        q      = (chk > P_W'(x2_reg)) ? qe - X_W'(1) : qe;
        qm     = msr_pkg::ang_t'(q);
        z_next = neg2_reg ? -qm : qm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= x_next;
            neg1_reg <= in_neg;
            p2_reg   <= p_next;
            x2_reg   <= x1_reg;
            neg2_reg <= neg1_reg;
            z3_reg   <= z_next;
        end
    end

    assign out_vld = vld3_reg;
    assign out_z   = z3_reg;

endmodule

>>> src/msr_cordic_rot.sv
// Pipelined CORDIC sine/cosine with range reduction.
module msr_cordic_rot #(
    parameter int ITER = msr_pkg::CORDIC_ITERATIONS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  msr_pkg::ang_t in_z,
    output logic          out_vld,
    output msr_pkg::q16_t out_sin,
    output msr_pkg::q16_t out_cos
);

    localparam int CW = 20;
    typedef logic signed [CW-1:0] cw_t;

    localparam msr_pkg::ang_t TWO  = msr_pkg::ang_t'(msr_pkg::Q_TWO_PI);
    localparam msr_pkg::ang_t PI   = msr_pkg::ang_t'(msr_pkg::Q_PI);
    localparam msr_pkg::ang_t HALF = msr_pkg::ang_t'(msr_pkg::Q_HALF_PI);

    logic          vld1_reg;
    msr_pkg::ang_t z1_reg;
    logic          vld_reg  [0:ITER];
    logic          flip_reg [0:ITER];
    cw_t           x_reg    [0:ITER];
    cw_t           y_reg    [0:ITER];
    msr_pkg::ang_t z_reg    [0:ITER];
    logic          out_vld_reg;
    msr_pkg::q16_t sin_reg, cos_reg;

    msr_pkg::ang_t zr_next, zf_next;
    logic          flip_next;

    // wrap into (-pi, pi]; the argument stays within one turn below zero and two turns above
    always_comb begin
        if (in_z < 0) begin
            zr_next = in_z + TWO;
        end else if (in_z >= TWO) begin
            zr_next = in_z - TWO;
        end else begin
            zr_next = in_z;
        end
        if (zr_next > PI) begin
            zr_next = zr_next - TWO;
        end
    end

    // fold into [-pi/2, pi/2], cosine sign flips
    always_comb begin
        flip_next = 1'b0;
        zf_next   = z1_reg;
        if (z1_reg > HALF) begin
            zf_next   = PI - z1_reg;
            flip_next = 1'b1;
        end else if (z1_reg < -HALF) begin
            zf_next   = -PI - z1_reg;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld1_reg   <= in_vld;
            vld_reg[0] <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg      <= zr_next;
            z_reg[0]    <= zf_next;
            flip_reg[0] <= flip_next;
            x_reg[0]    <= cw_t'(msr_pkg::Q_GAIN);
            y_reg[0]    <= '0;
        end
    end

    for (genvar g = 0; g < ITER; g++) begin : g_iter
        localparam msr_pkg::ang_t ATAN = msr_pkg::ang_t'(msr_pkg::ATAN_Q16[g]);
        cw_t dx, dy;
        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[g+1] <= flip_reg[g];
                if (z_reg[g] >= 0) begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - ATAN;
                end else begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + ATAN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= msr_pkg::Q_W'(y_reg[ITER]);
            cos_reg <= flip_reg[ITER] ? -msr_pkg::Q_W'(x_reg[ITER])
                                      : msr_pkg::Q_W'(x_reg[ITER]);
        end
    end

    assign out_vld = out_vld_reg;
    assign out_sin = sin_reg;
    assign out_cos = cos_reg;

endmodule

>>> src/msr_isqrt.sv
// Pipelined floor square root, one root bit per stage.
module msr_isqrt #(
    parameter int RW   = msr_pkg::SQ_RAD_W,
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [RW-1:0]     in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_vld,
    output logic [RW/2-1:0]   out_root,
    output logic [SB_W-1:0]   out_sb
);

    localparam int NS  = RW / 2;
    localparam int RMW = NS + 4;

    logic            vld_reg  [0:NS];
    logic [RW-1:0]   rad_reg  [0:NS];
    logic [RMW-1:0]  rem_reg  [0:NS];
    logic [NS-1:0]   root_reg [0:NS];
    logic [SB_W-1:0] sb_reg   [0:NS];

    // stage zero is the input itself
    assign vld_reg[0]  = in_vld;
    assign rad_reg[0]  = in_rad;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign sb_reg[0]   = in_sb;

    for (genvar g = 0; g < NS; g++) begin : g_step
        logic [RMW-1:0] rem_sh, trial;
        logic           take;
        assign rem_sh = {rem_reg[g][RMW-3:0], rad_reg[g][RW-1:RW-2]};
        assign trial  = RMW'({root_reg[g], 2'b01});
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[g+1]  <= rad_reg[g] << 2;
                rem_reg[g+1]  <= take ? rem_sh - trial : rem_sh;
                root_reg[g+1] <= {root_reg[g][NS-2:0], take};
                sb_reg[g+1]   <= sb_reg[g];
            end
        end
    end

    assign out_vld  = vld_reg[NS];
    assign out_root = root_reg[NS];
    assign out_sb   = sb_reg[NS];

endmodule

>>> src/msr_cordic_vec.sv
// Pipelined CORDIC vectoring: angle of (x, y) for y >= 0, clamped to 0..pi.
module msr_cordic_vec #(
    parameter int ITER = msr_pkg::CORDIC_ITERATIONS,
    parameter int SB_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [msr_pkg::ROOT_W-1:0] in_y,
    input  msr_pkg::q16_t              in_x,
    input  logic [SB_W-1:0]            in_sb,
    output logic                       out_vld,
    output logic [msr_pkg::H_W-1:0]    out_h,
    output logic [SB_W-1:0]            out_sb
);

    localparam int VW = 20;
    typedef logic signed [VW-1:0] vw_t;

    localparam msr_pkg::ang_t PI   = msr_pkg::ang_t'(msr_pkg::Q_PI);
    localparam msr_pkg::ang_t HALF = msr_pkg::ang_t'(msr_pkg::Q_HALF_PI);

    logic            vld_reg  [0:ITER];
    logic            zero_reg [0:ITER];
    vw_t             x_reg    [0:ITER];
    vw_t             y_reg    [0:ITER];
    msr_pkg::ang_t   z_reg    [0:ITER];
    logic [SB_W-1:0] sb_reg   [0:ITER];
    logic                    out_vld_reg;
    logic [msr_pkg::H_W-1:0] h_reg;
    logic [SB_W-1:0]         sb_out_reg;

    vw_t           xi, yi, x_next, y_next;
    msr_pkg::ang_t z_next, zc;

    // left half-plane: rotate by -pi/2 first and start the angle at pi/2
    always_comb begin
        xi = vw_t'(in_x);
        yi = vw_t'({1'b0, in_y});
        if (xi < 0) begin
            x_next = yi;
            y_next = -xi;
            z_next = HALF;
        end else begin
            x_next = xi;
            y_next = yi;
            z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (in_y == '0) && (in_x == '0);
            sb_reg[0]   <= in_sb;
        end
    end

    for (genvar g = 0; g < ITER; g++) begin : g_iter
        localparam msr_pkg::ang_t ATAN = msr_pkg::ang_t'(msr_pkg::ATAN_Q16[g]);
        vw_t dx, dy;
        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[g+1] <= zero_reg[g];
                sb_reg[g+1]   <= sb_reg[g];
                if (y_reg[g] > 0) begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + ATAN;
                end else begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - ATAN;
                end
            end
        end
    end

    always_comb begin
        if (zero_reg[ITER]) begin
            zc = HALF;
        end else if (z_reg[ITER] < 0) begin
            zc = '0;
        end else if (z_reg[ITER] > PI) begin
            zc = PI;
        end else begin
            zc = z_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg      <= msr_pkg::H_W'(zc);
            sb_out_reg <= sb_reg[ITER];
        end
    end

    assign out_vld = out_vld_reg;
    assign out_h   = h_reg;
    assign out_sb  = sb_out_reg;

endmodule

>>> src/max_solar_radiation_calc_unit.sv
// Maximum daily extraterrestrial solar radiation: top level pipeline.
//
// Input stream (s_*): one request per day of year and latitude in hundredths
// of a degree. Output stream (m_*): one request per input, the maximum daily
// radiation in unsigned fixed point MJ/m2 with OUT_FRAC_BITS fraction bits,
// saturated to 0..65535. Results leave in input order.
// The pipeline is a chain of two CORDIC pipelines, two bit-per-stage square
// roots and the divider and multiplier stages. Throughput is one request per
// cycle while the receiver does not stall.
// Every stage carries a valid bit; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline keeps moving
// as long as its last stage is empty, so bubbles close up; once a result
// sits at both the output register and the last stage, s_tready drops and
// everything holds, nothing is lost or repeated.
// A synchronous reset (aresetn low) clears all valid bits; the block has no
// other state.
module max_solar_radiation_calc_unit #(
    parameter int CORDIC_ITERATIONS = msr_pkg::CORDIC_ITERATIONS,
    parameter int OUT_FRAC_BITS     = msr_pkg::OUT_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [8:0] day_of_year, [23:9] latitude
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] max_radiation
);

    localparam int SH  = 48 - OUT_FRAC_BITS;
    localparam int P_W = 52;
    localparam int R_W = P_W + 5;
    localparam int RW  = msr_pkg::SQ_RAD_W;
    localparam int RTW = msr_pkg::ROOT_W;

    typedef struct packed {
        msr_pkg::q16_t ys;
        msr_pkg::q16_t clat;
        msr_pkg::q16_t dd;
    } sq1_sb_t;

    typedef struct packed {
        msr_pkg::q16_t ys;
        msr_pkg::q16_t dd;
        logic          polar;
        logic          mid;
    } sq2_sb_t;

    typedef struct packed {
        logic [RTW-1:0] w;
        sq2_sb_t        rest;
    } vec_sb_t;

    logic en;
    logic m_valid_reg;
    logic f2_vld_reg;

    assign en       = m_tready | ~m_valid_reg | ~f2_vld_reg;
    assign s_tready = en;

    // input stage, latitude saturated to the poles
    logic                p0_vld_reg;
    logic [8:0]          day_p0_reg;
    logic signed [14:0]  lat_p0_reg;
    logic signed [14:0]  lat_in, lat_sat;

    always_comb begin
        lat_in = signed'(s_tdata[23:9]);
        if (lat_in > 15'(msr_pkg::LAT_LIMIT)) begin
            lat_sat = 15'(msr_pkg::LAT_LIMIT);
        end else if (lat_in < -15'(msr_pkg::LAT_LIMIT)) begin
            lat_sat = -15'(msr_pkg::LAT_LIMIT);
        end else begin
            lat_sat = lat_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            day_p0_reg <= s_tdata[8:0];
            lat_p0_reg <= lat_sat;
        end
    end

    // angle arguments
    logic signed [9:0] dsd;
    logic              sd_neg, lat_neg;
    logic [8:0]        sd_mag;
    logic [13:0]       lat_mag;

    always_comb begin
        dsd     = signed'({1'b0, day_p0_reg}) - 10'(msr_pkg::DAY_OFFSET);
        sd_neg  = dsd[9];
        sd_mag  = sd_neg ? 9'(-dsd) : 9'(dsd);
        lat_neg = lat_p0_reg[14];
        lat_mag = lat_neg ? 14'(-lat_p0_reg) : 14'(lat_p0_reg);
    end

    logic          a_vld;
    msr_pkg::ang_t z_sd, z_dd, z_lat;

    msr_argdiv #(
        .MAG_W(9), .X_W(32), .SCALE(msr_pkg::DAY_SCALE),
        .BIAS(msr_pkg::DAY_DIV / 2), .DIVISOR(msr_pkg::DAY_DIV)
    ) u_arg_sd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(p0_vld_reg), .in_neg(sd_neg), .in_mag(sd_mag),
        .out_vld(), .out_z(z_sd)
    );

    msr_argdiv #(
        .MAG_W(9), .X_W(32), .SCALE(msr_pkg::DAY_SCALE),
        .BIAS(msr_pkg::DAY_DIV / 2), .DIVISOR(msr_pkg::DAY_DIV)
    ) u_arg_dd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(p0_vld_reg), .in_neg(1'b0), .in_mag(day_p0_reg),
        .out_vld(), .out_z(z_dd)
    );

    msr_argdiv #(
        .MAG_W(14), .X_W(35), .SCALE(msr_pkg::LAT_SCALE),
        .BIAS(msr_pkg::LAT_DIV / 2), .DIVISOR(msr_pkg::LAT_DIV)
    ) u_arg_lat (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(p0_vld_reg), .in_neg(lat_neg), .in_mag(lat_mag),
        .out_vld(a_vld), .out_z(z_lat)
    );

    // sines and cosines
    logic          r_vld;
    msr_pkg::q16_t sin_sd, cos_dd, slat, clat;

    msr_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_sd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(a_vld), .in_z(z_sd),
        .out_vld(), .out_sin(sin_sd), .out_cos()
    );

    msr_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_dd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(a_vld), .in_z(z_dd),
        .out_vld(), .out_sin(), .out_cos(cos_dd)
    );

    msr_cordic_rot #(.ITER(CORDIC_ITERATIONS)) u_rot_lat (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(a_vld), .in_z(z_lat),
        .out_vld(r_vld), .out_sin(slat), .out_cos(clat)
    );

    // declination sine and eccentricity factor
    logic          m1_vld_reg;
    msr_pkg::q16_t ssd_m1_reg, dd_m1_reg, slat_m1_reg, clat_m1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ssd_m1_reg  <= msr_pkg::qmul(sin_sd, msr_pkg::q16_t'(msr_pkg::SIN_TILT));
            dd_m1_reg   <= msr_pkg::q16_t'(msr_pkg::Q_ONE)
                         + msr_pkg::qmul(cos_dd, msr_pkg::q16_t'(msr_pkg::ECC));
            slat_m1_reg <= slat;
            clat_m1_reg <= clat;
        end
    end

    // 1 - ssd^2 and ys
    logic                    m2_vld_reg;
    logic [RW-1:0]           rad1_m2_reg;
    sq1_sb_t                 sb1_m2_reg;
    logic signed [35:0]      ssd_sq;
    logic [RW-1:0]           rad1_next;

    always_comb begin
        ssd_sq    = 36'(ssd_m1_reg) * 36'(ssd_m1_reg);
        rad1_next = RW'(64'sd4294967296 - 64'(ssd_sq));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad1_m2_reg     <= rad1_next;
            sb1_m2_reg.ys   <= msr_pkg::qmul(slat_m1_reg, ssd_m1_reg);
            sb1_m2_reg.clat <= clat_m1_reg;
            sb1_m2_reg.dd   <= dd_m1_reg;
        end
    end

    logic           sq1_vld;
    logic [RTW-1:0] csd;
    sq1_sb_t        sb1_out;

    msr_isqrt #(.RW(RW), .SB_W($bits(sq1_sb_t))) u_sqrt_csd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(m2_vld_reg), .in_rad(rad1_m2_reg), .in_sb(sb1_m2_reg),
        .out_vld(sq1_vld), .out_root(csd), .out_sb(sb1_out)
    );

    // yc, clipped at zero
    logic          m3_vld_reg;
    msr_pkg::q16_t yc_m3_reg, ys_m3_reg, dd_m3_reg;
    msr_pkg::q16_t yc_raw;

    assign yc_raw = msr_pkg::qmul(sb1_out.clat, msr_pkg::q16_t'({1'b0, csd}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_vld_reg <= 1'b0;
        end else if (en) begin
            m3_vld_reg <= sq1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yc_m3_reg <= (yc_raw < 0) ? '0 : yc_raw;
            ys_m3_reg <= sb1_out.ys;
            dd_m3_reg <= sb1_out.dd;
        end
    end

    // polar night / midnight sun and yc^2 - ys^2
    logic               m4_vld_reg;
    logic [RW-1:0]      rad2_m4_reg;
    sq2_sb_t            sb2_m4_reg;
    logic               polar_next, mid_next;
    logic signed [35:0] yc_sq, ys_sq;
    logic [RW-1:0]      rad2_next;

    always_comb begin
        polar_next = (-ys_m3_reg) > yc_m3_reg;
        mid_next   = ys_m3_reg > yc_m3_reg;
        yc_sq      = 36'(yc_m3_reg) * 36'(yc_m3_reg);
        ys_sq      = 36'(ys_m3_reg) * 36'(ys_m3_reg);
        rad2_next  = (polar_next || mid_next) ? '0 : RW'(yc_sq - ys_sq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_vld_reg <= 1'b0;
        end else if (en) begin
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad2_m4_reg      <= rad2_next;
            sb2_m4_reg.ys    <= ys_m3_reg;
            sb2_m4_reg.dd    <= dd_m3_reg;
            sb2_m4_reg.polar <= polar_next;
            sb2_m4_reg.mid   <= mid_next;
        end
    end

    logic           sq2_vld;
    logic [RTW-1:0] w_root;
    sq2_sb_t        sb2_out;

    msr_isqrt #(.RW(RW), .SB_W($bits(sq2_sb_t))) u_sqrt_w (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(m4_vld_reg), .in_rad(rad2_m4_reg), .in_sb(sb2_m4_reg),
        .out_vld(sq2_vld), .out_root(w_root), .out_sb(sb2_out)
    );

    // sunset hour angle
    logic                    v_vld;
    logic [msr_pkg::H_W-1:0] h_raw;
    vec_sb_t                 vsb_in, vsb_out;

    assign vsb_in.w    = w_root;
    assign vsb_in.rest = sb2_out;

    msr_cordic_vec #(.ITER(CORDIC_ITERATIONS), .SB_W($bits(vec_sb_t))) u_vec_h (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(sq2_vld), .in_y(w_root), .in_x(-sb2_out.ys), .in_sb(vsb_in),
        .out_vld(v_vld), .out_h(h_raw), .out_sb(vsb_out)
    );

    // t = h*ys + w (Q32)
    logic                    f1_vld_reg;
    logic signed [36:0]      t_f1_reg;
    msr_pkg::q16_t           dd_f1_reg;
    logic [msr_pkg::H_W-1:0] h_sel;
    logic [RTW-1:0]          w_sel;
    logic signed [36:0]      h_ext, ys_ext, w_ext;

    always_comb begin
        priority if (vsb_out.rest.polar) begin
            h_sel = '0;
            w_sel = '0;
        end else if (vsb_out.rest.mid) begin
            h_sel = msr_pkg::H_W'(msr_pkg::Q_PI);
            w_sel = '0;
        end else begin
            h_sel = h_raw;
            w_sel = vsb_out.w;
        end
        h_ext  = 37'(signed'({1'b0, h_sel}));
        ys_ext = 37'(vsb_out.rest.ys);
        w_ext  = 37'(signed'({1'b0, w_sel, 16'b0}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= v_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_f1_reg  <= h_ext * ys_ext + w_ext;
            dd_f1_reg <= vsb_out.rest.dd;
        end
    end

    // t * dd
    logic           pos_f2_reg;
    logic [P_W-1:0] p_f2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_f2_reg <= t_f1_reg > 0;
            p_f2_reg   <= P_W'(t_f1_reg[34:0]) * P_W'(dd_f1_reg[16:0]);
        end
    end

    // *30, round, saturate
    logic [R_W-1:0] p30, r_full;
    logic [15:0]    r_next;

    always_comb begin
        p30    = {p_f2_reg, 5'b0} - R_W'({p_f2_reg, 1'b0});
        r_full = (p30 + (R_W'(1) << (SH - 1))) >> SH;
        if (!pos_f2_reg) begin
            r_next = '0;
        end else if (r_full > R_W'(16'hFFFF)) begin
            r_next = 16'hFFFF;
        end else begin
            r_next = 16'(r_full);
        end
    end

    logic [15:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            m_valid_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if ((m_tready || !m_valid_reg) && f2_vld_reg) begin
            m_data_reg <= r_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> verif/max_solar_radiation_calc_unit_tb.sv
// Self-checking testbench for the maximum solar radiation pipeline.
module max_solar_radiation_calc_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM   = 2000;
    localparam int CALM_TAIL    = 300;
    localparam int LATENCY      = 2*msr_pkg::CORDIC_ITERATIONS + 50;
    localparam int STALL_LIMIT  = 20*LATENCY + 2000;
    localparam int NUM_DIRECTED = 22;
    localparam int NO_GOLDEN    = -1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [8:0] day_of_year, [23:9] latitude
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] max_radiation

    logic [15:0] radiation_due[$];
    int          mismatches;
    int          quiet_cycles;
    bit          calm;
    bit          stim_done;

    typedef struct {
        logic [8:0]  day;
        logic [14:0] lat;
        int          golden;
    } day_lat_row_t;

    max_solar_radiation_calc_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- radiation predictor ----------------
    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den/2) / den;
        return -((-num + den/2) / den);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a*b + 32768) >>> 16;
    endfunction

    function automatic void rotate_angle(input longint ang, output longint s_out,
                                         output longint c_out);
        longint x, y, z, dx, dy;
        bit     flip;
        x = msr_pkg::Q_GAIN;
        y = 0;
        flip = 0;
        z = ((ang % msr_pkg::Q_TWO_PI) + msr_pkg::Q_TWO_PI) % msr_pkg::Q_TWO_PI;
        if (z > msr_pkg::Q_PI) z = z - msr_pkg::Q_TWO_PI;
        if (z > msr_pkg::Q_HALF_PI) begin
            z = msr_pkg::Q_PI - z;
            flip = 1;
        end else if (z < -msr_pkg::Q_HALF_PI) begin
            z = -msr_pkg::Q_PI - z;
            flip = 1;
        end
        for (int i = 0; i < msr_pkg::CORDIC_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(msr_pkg::ATAN_Q16[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(msr_pkg::ATAN_Q16[i]);
            end
        end
        s_out = y;
        c_out = flip ? -x : x;
    endfunction

    function automatic longint hour_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (y == 0 && x == 0) return msr_pkg::Q_HALF_PI;
        if (x < 0) begin
            t = x; x = y; y = -t; z = msr_pkg::Q_HALF_PI;
        end
        for (int i = 0; i < msr_pkg::CORDIC_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + longint'(msr_pkg::ATAN_Q16[i]);
            end else begin
                x = x - dx; y = y + dy; z = z - longint'(msr_pkg::ATAN_Q16[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > msr_pkg::Q_PI) z = msr_pkg::Q_PI;
        return z;
    endfunction

    function automatic logic [15:0] predict_radiation(logic [8:0] day_f, logic [14:0] lat_f);
        longint            day, lat, sv, cv, slat, clat, ssd, csd, ecc_f, ys, yc, h, w, t;
        longint unsigned   r;
        day = longint'(day_f);
        lat = longint'($signed(lat_f));
        if (lat > msr_pkg::LAT_LIMIT) lat = msr_pkg::LAT_LIMIT;
        if (lat < -msr_pkg::LAT_LIMIT) lat = -msr_pkg::LAT_LIMIT;

        rotate_angle(round_div((day - msr_pkg::DAY_OFFSET) * msr_pkg::DAY_SCALE,
                               msr_pkg::DAY_DIV), sv, cv);
        ssd = fx_mul(sv, msr_pkg::SIN_TILT);
        csd = root_floor(longint'(msr_pkg::Q_ONE) * msr_pkg::Q_ONE - ssd * ssd);
        rotate_angle(round_div(day * msr_pkg::DAY_SCALE, msr_pkg::DAY_DIV), sv, cv);
        ecc_f = msr_pkg::Q_ONE + fx_mul(cv, msr_pkg::ECC);
        rotate_angle(round_div(lat * msr_pkg::LAT_SCALE, msr_pkg::LAT_DIV), slat, clat);
        ys = fx_mul(slat, ssd);
        yc = fx_mul(clat, csd);
        if (yc < 0) yc = 0;

        if (-ys > yc) begin
            h = 0; w = 0;             // polar night
        end else if (ys > yc) begin
            h = msr_pkg::Q_PI; w = 0; // midnight sun
        end else begin
            w = root_floor(yc*yc - ys*ys);
            h = hour_angle(w, -ys);
        end

        t = h*ys + w*msr_pkg::Q_ONE;
        if (t <= 0 || ecc_f <= 0) return 16'd0;
        r = (longint'(t) * longint'(ecc_f) * 30 + (64'd1 << (47 - msr_pkg::OUT_FRAC_BITS)))
            >> (48 - msr_pkg::OUT_FRAC_BITS);
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    // ---------------- stimulus ----------------
    day_lat_row_t directed_rows [NUM_DIRECTED] = '{
        // poles in their dark season give nothing
        '{9'd355, 15'(9000),   0},
        '{9'd172, 15'(-9000),  0},
        // latitude beyond the poles saturates
        '{9'd355, 15'h3FFF,    0},
        '{9'd172, 15'h4000,    0},
        '{9'd1,   15'(0),      NO_GOLDEN},
        '{9'd366, 15'(0),      NO_GOLDEN},
        '{9'd172, 15'(9000),   NO_GOLDEN},
        '{9'd355, 15'(-9000),  NO_GOLDEN},
        '{9'd82,  15'(9000),   NO_GOLDEN},
        '{9'd82,  15'(-9000),  NO_GOLDEN},
        '{9'd265, 15'(9000),   NO_GOLDEN},
        '{9'd172, 15'(7000),   NO_GOLDEN},
        '{9'd355, 15'(7000),   NO_GOLDEN},
        '{9'd172, 15'(-7000),  NO_GOLDEN},
        '{9'd200, 15'(-2345),  NO_GOLDEN},
        '{9'd0,   15'(4500),   NO_GOLDEN},
        '{9'd511, 15'(-4500),  NO_GOLDEN},
        '{9'd367, 15'(1),      NO_GOLDEN},
        '{9'd256, 15'(-1),     NO_GOLDEN},
        '{9'd172, 15'h3FFF,    NO_GOLDEN},
        '{9'd355, 15'h4000,    NO_GOLDEN},
        '{9'd100, 15'(8999),   NO_GOLDEN}
    };

    task automatic send_request(logic [8:0] day, logic [14:0] lat);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(9, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lat, day};
        do @(posedge aclk); while (!s_tready);
    endtask

    // expectations are queued at the edge that accepts the request
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            radiation_due.push_back(predict_radiation(s_tdata[8:0], s_tdata[23:9]));
    end

    initial begin
        logic [8:0]  day;
        logic [14:0] lat;
        int          sel;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        mismatches = 0;
        calm      = 0;
        stim_done = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].day, directed_rows[i].lat);
            if (directed_rows[i].golden != NO_GOLDEN &&
                predict_radiation(directed_rows[i].day, directed_rows[i].lat) !=
                16'(directed_rows[i].golden)) begin
                $display("%0t: table row %0d: expected %0d, predictor gives %0d", $time, i,
                         directed_rows[i].golden,
                         predict_radiation(directed_rows[i].day, directed_rows[i].lat));
                mismatches++;
            end
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n >= NUM_RANDOM - CALM_TAIL) calm = 1;
            sel = $urandom_range(9);
            if (sel == 0) begin
                // anything the fields can carry
                day = 9'($urandom);
                lat = 15'($urandom);
            end else if (sel == 1) begin
                day = 9'($urandom_range(366, 1));
                lat = $urandom_range(1) ? 15'($urandom_range(9000, 8000))
                                        : 15'(-$urandom_range(9000, 8000));
            end else begin
                day = 9'($urandom_range(366, 1));
                lat = 15'($urandom_range(18000) - 9000);
            end
            send_request(day, lat);
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // receiver stalls in bursts
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!calm && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(9, 1)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
    end

    // ---------------- result check ----------------
    always @(posedge aclk) begin
        logic [15:0] due;
        if (aresetn && m_tvalid && m_tready) begin
            if (radiation_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, m_tdata);
                mismatches++;
            end else begin
                due = radiation_due.pop_front();
                if (m_tdata !== due) begin
                    $display("%0t: max_radiation mismatch, expected %0d, actual %0d",
                             $time, due, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL max_solar_radiation_calc_unit");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
        wait (stim_done);
        while (radiation_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS max_solar_radiation_calc_unit");
        else
            $display("FAIL max_solar_radiation_calc_unit");
        $finish;
    end

endmodule
